// File: hw/rtl/fhb_pkg.sv
// ----------------------------------------------------------------------------
// fhb_pkg: shared types, constants and functions of the bucket letter unit
// Holds the hash constants, the register map, the modulo table and the
// transfer struct between the name core and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

package fhb_pkg;

  // Hash shift amounts and bucket modulus.
  localparam int unsigned DIR_X = 3;
  localparam int unsigned DIR_Y = 5;
  localparam int unsigned DIR_P = 23;

  // Character codes.
  localparam logic [6:0] DIR_A        = 7'd65;   // 'A'
  localparam logic [6:0] PLAIN_DFLT   = 7'd113;  // 'q'
  localparam logic [7:0] DOT_BYTE     = 8'd46;   // '.'
  localparam logic [7:0] END_BYTE     = 8'd0;
  localparam logic [7:0] UPPER_FIRST  = 8'd65;
  localparam logic [7:0] UPPER_LAST   = 8'd90;
  localparam logic [7:0] LOWER_FIRST  = 8'd97;
  localparam logic [7:0] LOWER_LAST   = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Configuration port geometry and register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_HASH_MODE = 1'b0;  // word index, paddr[2]

  localparam int unsigned HASH_W = 32;

  // One result leaving the name core.
  typedef struct packed {
    logic       valid;
    logic [6:0] letter;
  } letter_xfer_t;

  // Residue table for 8-bit values modulo DIR_P, built by counting.
  typedef logic [4:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t    tab;
    logic [4:0]  r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = r;
      r = (r == 5'(DIR_P - 1)) ? 5'd0 : 5'(r + 5'd1);
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // One step of the running hash.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    return ((h << DIR_X) ^ (h >> DIR_Y)) ^ {24'd0, b};
  endfunction

  // Hashed letter: 256^k mod 23 is 1, 3, 9, 4, so the byte lanes fold into
  // a small sum, which two more folds bring under 256 for the table.
  function automatic logic [6:0] hash_letter(input logic [HASH_W-1:0] h);
    logic [12:0] s0;
    logic [8:0]  s1;
    logic [8:0]  s2;
    s0 = 13'(h[7:0]) + 13'(h[15:8]) * 13'd3 + 13'(h[23:16]) * 13'd9
       + 13'(h[31:24]) * 13'd4;
    s1 = 9'(s0[7:0]) + 9'(s0[12:8]) * 9'd3;
    s2 = 9'(s1[7:0]) + (s1[8] ? 9'd3 : 9'd0);
    return DIR_A + 7'(MOD_TAB[s2[7:0]]);
  endfunction

  // Plain letter: first byte lowered to a-z, else 'q'.
  function automatic logic [6:0] plain_letter(input logic [7:0] b);
    logic [6:0] res;
    if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
      res = 7'(b + CASE_OFFSET);
    end else if (b >= LOWER_FIRST && b <= LOWER_LAST) begin
      res = b[6:0];
    end else begin
      res = PLAIN_DFLT;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fhb_cfg.sv
// ----------------------------------------------------------------------------
// fhb_cfg: configuration register block
// APB-style slave holding the hash_mode register; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fhb_cfg
  import fhb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic                       hash_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= 1'b1;
    end else if (wr_en && paddr[2] == REG_HASH_MODE) begin
      hash_mode <= pwdata[0];
    end
  end

  // Read decode; addresses outside the map read as zero.
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_HASH_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, hash_mode};
      default:       prdata = '0;
    endcase
  end

  // The low address bits select bytes inside the word and carry no decode.
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

// File: hw/rtl/fhb_core.sv
// ----------------------------------------------------------------------------
// fhb_core: name tracking core
// Registers each incoming byte, updates the hash and first-byte state, and
// forms the bucket letter when the closing zero byte is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module fhb_core
  import fhb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] name_byte,
  input  wire logic       hash_mode,
  input  wire logic       res_free,
  output letter_xfer_t    res
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_is_end;
  logic              s1_fire;
  logic              s1_load;

  logic [HASH_W-1:0] running_hash;
  logic              dot_seen;
  logic              at_name_start;
  logic [7:0]        first_byte;
  logic              dot_now;

  // A closing byte moves on only when the result register can take it.
  assign s1_is_end = (s1_byte == END_BYTE);
  assign s1_fire   = s1_valid && (!s1_is_end || res_free);
  assign s1_load   = !s1_valid || s1_fire;
  assign in_stall  = !s1_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte <= name_byte;
    end
  end

  assign dot_now = dot_seen || (s1_byte == DOT_BYTE);

  // Name state: cleared by the closing byte, updated by every other byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= '0;
      dot_seen      <= 1'b0;
      at_name_start <= 1'b1;
      first_byte    <= '0;
    end else if (s1_fire) begin
      if (s1_is_end) begin
        running_hash  <= '0;
        dot_seen      <= 1'b0;
        at_name_start <= 1'b1;
        first_byte    <= '0;
      end else begin
        if (at_name_start) begin
          first_byte    <= s1_byte;
          at_name_start <= 1'b0;
        end
        dot_seen <= dot_now;
        if (!dot_now) begin
          running_hash <= hash_step(running_hash, s1_byte);
        end
      end
    end
  end

  // Letter for the closing byte.
  always_comb begin
    res.valid = s1_fire && s1_is_end;
    if (hash_mode) begin
      res.letter = hash_letter(running_hash);
    end else if (at_name_start) begin
      res.letter = PLAIN_DFLT;
    end else begin
      res.letter = plain_letter(first_byte);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fhb_out_reg.sv
// ----------------------------------------------------------------------------
// fhb_out_reg: result register
// Holds one bucket letter until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fhb_out_reg
  import fhb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire letter_xfer_t res,
  output logic              res_free,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [6:0]        bucket_char
);

  // Free when empty or when the held letter leaves this cycle.
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      bucket_char <= res.letter;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/filename_hash_bucket_char_unit.sv
// ----------------------------------------------------------------------------
// filename_hash_bucket_char_unit: bucket letter for streamed file names
// Takes a file name one byte per transfer and gives one bucket letter per
// name when its closing zero byte arrives, hashed or from the first letter.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   name_byte[7:0]
//   out       source     out_valid / out_stall bucket_char[6:0]
//   cfg       APB slave  psel/penable/pready   paddr[2:0], pwdata, prdata
//
// One byte is taken every cycle unless in_stall holds it; each byte is registered in the input register.
// A closing byte's letter is formed combinationally from the input register and
// is loaded into the result register as that byte leaves the input register.
// Reset is synchronous; it clears the name state and sets hash_mode to 1.
// A stalled result holds the result register; bytes of the next name keep
// flowing, and only a closing byte waits until the letter is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module filename_hash_bucket_char_unit
  import fhb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            name_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [6:0]            bucket_char,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic         hash_mode;
  logic         res_free;
  letter_xfer_t res;

  // Configuration registers.
  fhb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .hash_mode (hash_mode)
  );

  // Name tracking and letter forming.
  fhb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .name_byte (name_byte),
    .hash_mode (hash_mode),
    .res_free  (res_free),
    .res       (res)
  );

  // Result register.
  fhb_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .res_free    (res_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket_char (bucket_char)
  );

  // An empty result register never holds back input.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  // A letter is only pushed when the result register can take it.
  a_push_only_when_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res_free)
    else $error("letter pushed into a busy result register");

  // Every delivered letter is a hashed or a plain bucket letter.
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((bucket_char >= DIR_A && bucket_char <= 7'(DIR_A + 7'(DIR_P - 1)))
                || (bucket_char >= 7'd97 && bucket_char <= 7'd122)))
    else $error("bucket letter out of range");

endmodule

`default_nettype wire
